// ----- rtl/hoa_pkg.sv -----
package hoa_pkg;

  localparam int MAX_ORDER_DEF = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMBI_ORDER = 3'd0,
    CFG_LAYOUT_ROT = 3'd1,
    CFG_GAIN_SCALE = 3'd2,
    CFG_MAX_RE_ON  = 3'd3,
    CFG_RAMP_STEP  = 3'd4
  } cfg_idx_e;

  localparam logic [3:0]  AMBI_ORDER_RST = 4'd1;
  localparam logic [15:0] LAYOUT_ROT_RST = 16'd0;
  localparam logic [16:0] GAIN_SCALE_RST = 17'd21845;
  localparam logic        MAX_RE_ON_RST  = 1'b0;
  localparam logic [16:0] RAMP_STEP_RST  = 17'd65536;

  localparam logic CMD_DIR    = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [15:0]        QUARTER_TURN = 16'd16384;
  localparam logic signed [17:0] UNITY_Q16    = 18'sd65536;
  localparam int                 DIV_STEPS    = 15;

  // quarter-wave sine polynomial, Q30
  localparam logic signed [32:0] POLY_C1 = 33'sd1686629713;
  localparam logic signed [32:0] POLY_C3 = -33'sd693598668;
  localparam logic signed [32:0] POLY_C5 = 33'sd85569306;
  localparam logic signed [32:0] POLY_C7 = -33'sd5026995;
  localparam logic signed [32:0] POLY_C9 = 33'sd172272;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        azimuth;
    logic signed [23:0] sample;
  } in_t;

  typedef struct packed {
    logic [3:0]         harmonic_order;
    logic signed [31:0] coef_real;
    logic signed [31:0] coef_imag;
    logic               last;
  } out_t;

  typedef struct packed {
    logic signed [17:0] wr;
    logic signed [17:0] wi;
    logic signed [19:0] sr;
    logic signed [19:0] si;
  } ent_t;

  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic               done;
    logic signed [17:0] value;
  } trig_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_KNEXT,
    ST_MR,
    ST_MRW,
    ST_MAG,
    ST_COSW,
    ST_SINW,
    ST_TGT,
    ST_STEP,
    ST_SRD,
    ST_SUPD,
    ST_SMUL
  } st_e;

  // round half up at bit 16
  function automatic logic signed [47:0] rnd16(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [47:0] v);
    logic signed [17:0] r;
    if (v > 48'sd131071) begin
      r = 18'sd131071;
    end else if (v < -48'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [47:0] v);
    logic signed [19:0] r;
    if (v > 48'sd524287) begin
      r = 20'sd524287;
    end else if (v < -48'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/hoa2d_point_source_encoder_top.sv -----
// 2D circular harmonic encoder for one point source.
// Input channel (in_valid_i / in_stall_o / in_data_i): a transaction with
// cmd = direction loads a new azimuth and recomputes the per-order ramp
// steps; a transaction with cmd = sample ramps every active weight one step
// and emits one coefficient transaction per order, order 0 first, with last
// set on the highest active order.
// Output channel (out_valid_o / out_stall_i / out_data_o): one output
// register. While the receiver stalls, the held coefficient stays and the
// sequencer waits before loading the next one.
// Throughput: one input transaction at a time. A sample reads the entry of
// order 0, then for each order updates the weight in the state memory, whose
// read is registered, and forms the coefficient; a stalled output holds it.
// A direction runs the accept and the max-rE angle divider, then for each
// order calls the shared iterative sine unit for the max-rE gain (with
// max-rE), the cosine and the sine, and writes the new ramp step.
// Configuration writes (cfg_we_i) take effect at once and the user must make
// them while the block is idle; the block itself does not enforce this.
// Reset clears the configuration to defaults and marks every state entry
// invalid so that it reads as zero; no clearing pass is needed.
module hoa2d_point_source_encoder_top #(
  parameter int MAX_ORDER = hoa_pkg::MAX_ORDER_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  hoa_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output hoa_pkg::out_t                      out_data_o,
  input  logic                               cfg_we_i,
  input  logic [hoa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hoa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import hoa_pkg::*;

  localparam int DEPTH = MAX_ORDER + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int D_W   = IDX_W + 1;

  // configuration
  logic [3:0]  ambi_q;
  logic [15:0] rot_q;
  logic [16:0] gain_q;
  logic        mre_q;
  logic [16:0] ramp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambi_q <= AMBI_ORDER_RST;
      rot_q  <= LAYOUT_ROT_RST;
      gain_q <= GAIN_SCALE_RST;
      mre_q  <= MAX_RE_ON_RST;
      ramp_q <= RAMP_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AMBI_ORDER: ambi_q <= cfg_wdata_i[3:0];
        CFG_LAYOUT_ROT: rot_q  <= cfg_wdata_i[15:0];
        CFG_GAIN_SCALE: gain_q <= cfg_wdata_i;
        CFG_MAX_RE_ON:  mre_q  <= cfg_wdata_i[0];
        CFG_RAMP_STEP:  ramp_q <= cfg_wdata_i;
        default:        ambi_q <= ambi_q;
      endcase
    end
  end

  logic [IDX_W-1:0] ord;
  logic [D_W-1:0]   dvs;
  assign ord = (int'(ambi_q) > MAX_ORDER) ? IDX_W'(MAX_ORDER) : IDX_W'(ambi_q);
  assign dvs = D_W'(ord) + D_W'(1);

  // state memory
  ent_t             mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  ent_t             rd_raw_q, rd_ent, wd;
  logic             rd_vld_q;
  logic             mem_we, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wd;
    end
    if (rd_en) begin
      rd_raw_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  assign rd_ent = rd_vld_q ? rd_raw_q : '0;

  // sine unit
  trig_req_t trig_req;
  trig_rsp_t trig_rsp;

  hoa_sin u_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (trig_req),
    .rsp_o  (trig_rsp)
  );

  // sequencer
  st_e                st_q, st_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [3:0]         div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;
  logic [15:0]        base_q, base_d, ph_q, ph_d, mra_q, mra_d;
  logic [D_W-1:0]     mrr_q, mrr_d, rem_q, rem_d;
  logic [14:0]        num_q, num_d, q0_q, q0_d;
  logic signed [23:0] smp_q, smp_d;
  logic signed [17:0] mr_q, mr_d, cos_q, cos_d, sin_q, sin_d;
  logic signed [18:0] mag_q, mag_d;
  logic signed [17:0] tre_q, tre_d, tim_q, tim_d, wr_q, wr_d, wi_q, wi_d;

  logic               in_acc, out_load;
  logic [D_W:0]       rem_sh, rsum;
  logic               rwrap;
  logic signed [35:0] mag_prod;
  logic signed [36:0] tre_prod, tim_prod, sr_prod, si_prod;
  logic signed [18:0] dr, di;
  logic signed [20:0] wsum_r, wsum_i;
  logic signed [41:0] cr_prod, ci_prod;
  logic signed [47:0] mag_w, cr_w, ci_w;
  logic signed [17:0] wr_n, wi_n;
  logic signed [19:0] sr_n, si_n;

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    rem_sh   = {rem_q, num_q[14]};
    rsum     = {1'b0, mrr_q} + {1'b0, rem_q};
    rwrap    = (rsum >= {1'b0, dvs});
    mag_prod = $signed({1'b0, gain_q}) * mr_q;
    mag_w    = rnd16(48'(mag_prod));
    tre_prod = mag_q * cos_q;
    tim_prod = mag_q * sin_q;
    dr       = tre_q - rd_ent.wr;
    di       = tim_q - rd_ent.wi;
    sr_prod  = dr * $signed({1'b0, ramp_q});
    si_prod  = di * $signed({1'b0, ramp_q});
    sr_n     = sat20(rnd16(48'(sr_prod)));
    si_n     = sat20(rnd16(48'(si_prod)));
    wsum_r   = rd_ent.wr + rd_ent.sr;
    wsum_i   = rd_ent.wi + rd_ent.si;
    wr_n     = sat18(48'(wsum_r));
    wi_n     = sat18(48'(wsum_i));
    cr_prod  = wr_q * smp_q;
    ci_prod  = wi_q * smp_q;
    cr_w     = rnd16(48'(cr_prod));
    ci_w     = rnd16(48'(ci_prod));
  end

  always_comb begin
    st_d      = st_q;
    k_d       = k_q;
    div_cnt_d = div_cnt_q;
    base_d    = base_q;
    ph_d      = ph_q;
    mra_d     = mra_q;
    mrr_d     = mrr_q;
    rem_d     = rem_q;
    num_d     = num_q;
    q0_d      = q0_q;
    smp_d     = smp_q;
    mr_d      = mr_q;
    mag_d     = mag_q;
    cos_d     = cos_q;
    sin_d     = sin_q;
    tre_d     = tre_q;
    tim_d     = tim_q;
    wr_d      = wr_q;
    wi_d      = wi_q;
    out_d     = out_q;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    wr_addr   = '0;
    wd        = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    trig_req  = '0;

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          k_d = '0;
          if (in_data_i.cmd == CMD_DIR) begin
            base_d    = in_data_i.azimuth + rot_q;
            // order 0 is fixed at the gain and never ramps
            mem_we    = 1'b1;
            wr_addr   = '0;
            wd.wr     = $signed({1'b0, gain_q});
            rem_d     = '0;
            num_d     = 15'(QUARTER_TURN);
            q0_d      = '0;
            div_cnt_d = '0;
            ph_d      = '0;
            mra_d     = '0;
            mrr_d     = '0;
            st_d      = ST_DIV;
          end else begin
            smp_d = in_data_i.sample;
            st_d  = ST_SRD;
          end
        end
      end
      ST_DIV: begin
        // quarter turn divided by order+1, one quotient bit a cycle
        if (rem_sh >= {1'b0, dvs}) begin
          rem_d = D_W'(rem_sh - {1'b0, dvs});
          q0_d  = {q0_q[13:0], 1'b1};
        end else begin
          rem_d = rem_sh[D_W-1:0];
          q0_d  = {q0_q[13:0], 1'b0};
        end
        num_d     = {num_q[13:0], 1'b0};
        div_cnt_d = div_cnt_q + 4'd1;
        if (div_cnt_q == 4'(DIV_STEPS - 1)) begin
          st_d = (ord == '0) ? ST_IDLE : ST_KNEXT;
        end
      end
      ST_KNEXT: begin
        // advance phase and max-rE angle by one order
        k_d   = k_q + IDX_W'(1);
        ph_d  = ph_q + base_q;
        mra_d = mra_q + {1'b0, q0_q} + 16'(rwrap);
        mrr_d = rwrap ? D_W'(rsum - {1'b0, dvs}) : rsum[D_W-1:0];
        st_d  = ST_MR;
      end
      ST_MR: begin
        if (mre_q) begin
          trig_req.start = 1'b1;
          trig_req.angle = mra_q + QUARTER_TURN;
          st_d           = ST_MRW;
        end else begin
          mr_d = UNITY_Q16;
          st_d = ST_MAG;
        end
      end
      ST_MRW: begin
        if (trig_rsp.done) begin
          mr_d = trig_rsp.value;
          st_d = ST_MAG;
        end
      end
      ST_MAG: begin
        mag_d          = mag_w[18:0];
        trig_req.start = 1'b1;
        trig_req.angle = ph_q + QUARTER_TURN;
        st_d           = ST_COSW;
      end
      ST_COSW: begin
        if (trig_rsp.done) begin
          cos_d          = trig_rsp.value;
          trig_req.start = 1'b1;
          trig_req.angle = ph_q;
          st_d           = ST_SINW;
        end
      end
      ST_SINW: begin
        if (trig_rsp.done) begin
          sin_d   = trig_rsp.value;
          rd_en   = 1'b1;
          rd_addr = k_q;
          st_d    = ST_TGT;
        end
      end
      ST_TGT: begin
        tre_d = sat18(rnd16(48'(tre_prod)));
        tim_d = sat18(rnd16(-48'(tim_prod)));
        st_d  = ST_STEP;
      end
      ST_STEP: begin
        mem_we  = 1'b1;
        wr_addr = k_q;
        wd      = '{wr: rd_ent.wr, wi: rd_ent.wi, sr: sr_n, si: si_n};
        st_d    = (k_q == ord) ? ST_IDLE : ST_KNEXT;
      end
      ST_SRD: begin
        rd_en   = 1'b1;
        rd_addr = k_q;
        st_d    = ST_SUPD;
      end
      ST_SUPD: begin
        mem_we  = 1'b1;
        wr_addr = k_q;
        wd      = '{wr: wr_n, wi: wi_n, sr: rd_ent.sr, si: rd_ent.si};
        wr_d    = wr_n;
        wi_d    = wi_n;
        st_d    = ST_SMUL;
      end
      ST_SMUL: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load             = 1'b1;
          out_d.harmonic_order = 4'(k_q);
          out_d.coef_real      = cr_w[31:0];
          out_d.coef_imag      = ci_w[31:0];
          out_d.last           = (k_q == ord);
          if (k_q == ord) begin
            st_d = ST_IDLE;
          end else begin
            k_d     = k_q + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = k_q + IDX_W'(1);
            st_d    = ST_SUPD;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      k_q         <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      k_q         <= k_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    ph_q   <= ph_d;
    mra_q  <= mra_d;
    mrr_q  <= mrr_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    q0_q   <= q0_d;
    smp_q  <= smp_d;
    mr_q   <= mr_d;
    mag_q  <= mag_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
    tre_q  <= tre_d;
    tim_q  <= tim_d;
    wr_q   <= wr_d;
    wi_q   <= wi_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the sequencer never reads an entry in the cycle it writes one
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (wr_addr != rd_addr))
    else $error("state memory read and write overlap");

  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> (k_q <= ord))
    else $error("order counter beyond active order");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (st_q == ST_IDLE || st_q == ST_STEP || st_q == ST_SUPD))
    else $error("state memory written outside an update step");

  a_sine_single_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_req.start |=> !trig_req.start)
    else $error("sine unit started twice in a row");

endmodule

// ----- rtl/hoa_sin.sv -----
module hoa_sin (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hoa_pkg::trig_req_t   req_i,
  output hoa_pkg::trig_rsp_t   rsp_o
);
  import hoa_pkg::*;

  localparam logic signed [64:0] HALF30 = 65'sd1 <<< 29;
  localparam logic signed [64:0] HALF44 = 65'sd1 <<< 43;
  localparam logic [61:0]        HALF30U = 62'd1 << 29;

  logic               busy_q, done_q;
  logic [2:0]         cnt_q;
  logic [1:0]         quad_q;
  logic [30:0]        x_q, x2_q;
  logic signed [32:0] p_q;
  logic signed [17:0] y_q;

  logic [14:0]        r_fold;
  logic [61:0]        xx;
  logic [30:0]        x2_n;
  logic signed [32:0] coef;
  logic signed [64:0] px2, px, px2_r, px_r;
  logic signed [32:0] p_n;
  logic signed [20:0] y_raw;
  logic signed [17:0] y_mag, y_n;

  always_comb begin
    // odd quadrants run the polynomial backward from the quarter point
    if (req_i.angle[14]) begin
      r_fold = 15'(QUARTER_TURN) - {1'b0, req_i.angle[13:0]};
    end else begin
      r_fold = {1'b0, req_i.angle[13:0]};
    end
    xx   = 62'(x_q) * 62'(x_q);
    x2_n = 31'((xx + HALF30U) >> 30);
    case (cnt_q)
      3'd1:    coef = POLY_C7;
      3'd2:    coef = POLY_C5;
      3'd3:    coef = POLY_C3;
      3'd4:    coef = POLY_C1;
      default: coef = POLY_C7;
    endcase
    px2   = p_q * $signed({1'b0, x2_q});
    px2_r = (px2 + HALF30) >>> 30;
    p_n   = coef + px2_r[32:0];
    px    = p_q * $signed({1'b0, x_q});
    px_r  = (px + HALF44) >>> 44;
    y_raw = px_r[20:0];
    if (y_raw < 21'sd0) begin
      y_mag = 18'sd0;
    end else if (y_raw > 21'sd65536) begin
      y_mag = UNITY_Q16;
    end else begin
      y_mag = y_raw[17:0];
    end
    y_n = quad_q[1] ? -y_mag : y_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.start) begin
        quad_q <= req_i.angle[15:14];
        x_q    <= {r_fold, 16'd0};
        p_q    <= POLY_C9;
      end
    end else begin
      case (cnt_q)
        3'd0:                      x2_q <= x2_n;
        3'd1, 3'd2, 3'd3, 3'd4:    p_q  <= p_n;
        3'd5:                      y_q  <= y_n;
        default:                   p_q  <= p_q;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = y_q;

endmodule
